// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// No dependencies; every macro expects clk in scope, FATP_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while in reset.
`define FATP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, checked during reset as well.
`define FATP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/fatp_pkg.sv =====
// Shared types, field ids and status codes for the FLV/AVC tag parser.
// No dependencies.
package fatp_pkg;

  localparam int TOK_MAX = 3;                 // most tokens one byte can cause
  localparam logic [23:0] CNT_SAT = 24'hFFFFFF;
  localparam logic [3:0]  AVC_CODEC_RST = 4'd7;

  // Parse phases; numeric order matters for the end status decode
  typedef enum logic [4:0] {
    PH_TYPE, PH_SIZE, PH_TS, PH_TSX, PH_STREAM, PH_FIRST, PH_PKT,
    PH_CTS_CFG, PH_CTS_OTHER, PH_VER, PH_PROF, PH_COMPAT, PH_LEVEL,
    PH_NALLEN, PH_SPSCNT, PH_SPSLEN, PH_SPSBYTES, PH_PPSCNT, PH_PPSLEN,
    PH_PPSBYTES, PH_CHROMA, PH_LUMA, PH_CDEPTH, PH_SPSEXT, PH_PAYLOAD,
    PH_DROP
  } phase_t;

  // Field ids
  localparam logic [4:0] FID_TYPE    = 5'd0;
  localparam logic [4:0] FID_SIZE    = 5'd1;
  localparam logic [4:0] FID_TS      = 5'd2;
  localparam logic [4:0] FID_TSX     = 5'd3;
  localparam logic [4:0] FID_STREAM  = 5'd4;
  localparam logic [4:0] FID_FRAME   = 5'd5;
  localparam logic [4:0] FID_CODEC   = 5'd6;
  localparam logic [4:0] FID_PKT     = 5'd7;
  localparam logic [4:0] FID_CTS     = 5'd8;
  localparam logic [4:0] FID_VER     = 5'd9;
  localparam logic [4:0] FID_PROF    = 5'd10;
  localparam logic [4:0] FID_COMPAT  = 5'd11;
  localparam logic [4:0] FID_LEVEL   = 5'd12;
  localparam logic [4:0] FID_NALLEN  = 5'd13;
  localparam logic [4:0] FID_SPSCNT  = 5'd14;
  localparam logic [4:0] FID_SPSLEN  = 5'd15;
  localparam logic [4:0] FID_SPSBYTE = 5'd16;
  localparam logic [4:0] FID_PPSCNT  = 5'd17;
  localparam logic [4:0] FID_PPSLEN  = 5'd18;
  localparam logic [4:0] FID_PPSBYTE = 5'd19;
  localparam logic [4:0] FID_CHROMA  = 5'd20;
  localparam logic [4:0] FID_LUMA    = 5'd21;
  localparam logic [4:0] FID_CDEPTH  = 5'd22;
  localparam logic [4:0] FID_SPSEXT  = 5'd23;
  localparam logic [4:0] FID_PAYLOAD = 5'd24;
  localparam logic [4:0] FID_END     = 5'd25;

  // End status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_AVC  = 2'd1;
  localparam logic [1:0] ST_TRUNC_HDR = 2'd2;
  localparam logic [1:0] ST_TRUNC_REC = 2'd3;

  // One output token
  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] value;
    logic [4:0]  id;
  } token_t;

  // Parser status seen by the top level
  typedef struct packed {
    phase_t phase;
    logic   is_avc;
  } parse_stat_t;

  function automatic token_t mk_tok(input logic [4:0] id, input logic [23:0] value,
                                    input logic [1:0] status);
    token_t t;
    t.id = id;
    t.value = value;
    t.status = status;
    return t;
  endfunction

endpackage

// ===== hdl/fatp_parser.sv =====
// Byte-level parse state machine: turns each accepted byte into 0..3 tokens.
// Depends on fatp_pkg.
module fatp_parser
  import fatp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic              byte_fire,     // byte accepted this cycle
  input  logic [7:0]        data_byte,
  input  logic              tag_last,
  output token_t            toks [TOK_MAX],
  output logic [1:0]        ntok,
  output parse_stat_t       stat
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [15:0] psr_r, psr_nxt;
  logic [23:0] pcnt_r, pcnt_nxt;
  logic        avc_r, avc_nxt;
  logic [3:0]  codec_r;

  logic [23:0] gath_acc;
  logic [1:0]  gath_cnt;
  logic [1:0]  st;

  assign gath_acc = {acc_r[15:0], data_byte};
  assign gath_cnt = bif_r + 2'd1;

  // Next state and tokens for the byte at the input
  always_comb begin
    phase_nxt = phase_r;
    bif_nxt   = bif_r;
    acc_nxt   = acc_r;
    psr_nxt   = psr_r;
    pcnt_nxt  = pcnt_r;
    avc_nxt   = avc_r;
    st        = ST_OK;
    ntok      = 2'd0;
    for (int i = 0; i < TOK_MAX; i++) toks[i] = '0;

    case (phase_r)
      PH_TYPE: begin
        toks[ntok] = mk_tok(FID_TYPE, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        acc_nxt = '0;
        bif_nxt = '0;
        phase_nxt = PH_SIZE;
      end
      PH_SIZE, PH_TS, PH_STREAM, PH_CTS_CFG, PH_CTS_OTHER: begin
        // three-byte big-endian fields
        if (gath_cnt == 2'd3) begin
          case (phase_r)
            PH_SIZE:   begin toks[ntok] = mk_tok(FID_SIZE, gath_acc, ST_OK);
                             phase_nxt = PH_TS; end
            PH_TS:     begin toks[ntok] = mk_tok(FID_TS, gath_acc, ST_OK);
                             phase_nxt = PH_TSX; end
            PH_STREAM: begin toks[ntok] = mk_tok(FID_STREAM, gath_acc, ST_OK);
                             phase_nxt = PH_FIRST; end
            PH_CTS_CFG: begin toks[ntok] = mk_tok(FID_CTS, gath_acc, ST_OK);
                             phase_nxt = PH_VER; end
            default:   begin toks[ntok] = mk_tok(FID_CTS, gath_acc, ST_OK);
                             phase_nxt = PH_PAYLOAD; end
          endcase
          ntok = ntok + 2'd1;
          acc_nxt = '0;
          bif_nxt = '0;
        end else begin
          acc_nxt = gath_acc;
          bif_nxt = gath_cnt;
        end
      end
      PH_TSX: begin
        toks[ntok] = mk_tok(FID_TSX, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_STREAM;
      end
      PH_FIRST: begin
        toks[ntok] = mk_tok(FID_FRAME, {20'd0, data_byte[7:4]}, ST_OK); ntok = ntok + 2'd1;
        toks[ntok] = mk_tok(FID_CODEC, {20'd0, data_byte[3:0]}, ST_OK); ntok = ntok + 2'd1;
        avc_nxt = (data_byte[3:0] == codec_r);
        phase_nxt = avc_nxt ? PH_PKT : PH_DROP;
      end
      PH_PKT: begin
        toks[ntok] = mk_tok(FID_PKT, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = (data_byte == 8'h00) ? PH_CTS_CFG : PH_CTS_OTHER;
      end
      PH_VER: begin
        toks[ntok] = mk_tok(FID_VER, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_PROF;
      end
      PH_PROF: begin
        toks[ntok] = mk_tok(FID_PROF, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_COMPAT;
      end
      PH_COMPAT: begin
        toks[ntok] = mk_tok(FID_COMPAT, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_LEVEL;
      end
      PH_LEVEL: begin
        toks[ntok] = mk_tok(FID_LEVEL, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_NALLEN;
      end
      PH_NALLEN: begin
        toks[ntok] = mk_tok(FID_NALLEN, {22'd0, data_byte[1:0]}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_SPSCNT;
      end
      PH_SPSCNT: begin
        toks[ntok] = mk_tok(FID_SPSCNT, {19'd0, data_byte[4:0]}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_SPSLEN;
      end
      PH_SPSLEN, PH_PPSLEN: begin
        // two-byte parameter set length
        if (gath_cnt == 2'd2) begin
          toks[ntok] = mk_tok((phase_r == PH_SPSLEN) ? FID_SPSLEN : FID_PPSLEN,
                              {8'd0, gath_acc[15:0]}, ST_OK);
          ntok = ntok + 2'd1;
          psr_nxt = gath_acc[15:0];
          acc_nxt = '0;
          bif_nxt = '0;
          if (phase_r == PH_SPSLEN)
            phase_nxt = (gath_acc[15:0] != 16'd0) ? PH_SPSBYTES : PH_PPSCNT;
          else
            phase_nxt = (gath_acc[15:0] != 16'd0) ? PH_PPSBYTES : PH_CHROMA;
        end else begin
          acc_nxt = gath_acc;
          bif_nxt = gath_cnt;
        end
      end
      PH_SPSBYTES, PH_PPSBYTES: begin
        toks[ntok] = mk_tok((phase_r == PH_SPSBYTES) ? FID_SPSBYTE : FID_PPSBYTE,
                            {16'd0, data_byte}, ST_OK);
        ntok = ntok + 2'd1;
        psr_nxt = psr_r - 16'd1;
        if (psr_nxt == 16'd0)
          phase_nxt = (phase_r == PH_SPSBYTES) ? PH_PPSCNT : PH_CHROMA;
      end
      PH_PPSCNT: begin
        toks[ntok] = mk_tok(FID_PPSCNT, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_PPSLEN;
      end
      PH_CHROMA: begin
        toks[ntok] = mk_tok(FID_CHROMA, {22'd0, data_byte[1:0]}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_LUMA;
      end
      PH_LUMA: begin
        toks[ntok] = mk_tok(FID_LUMA, {21'd0, data_byte[2:0]}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_CDEPTH;
      end
      PH_CDEPTH: begin
        toks[ntok] = mk_tok(FID_CDEPTH, {21'd0, data_byte[2:0]}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_SPSEXT;
      end
      PH_SPSEXT: begin
        toks[ntok] = mk_tok(FID_SPSEXT, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        toks[ntok] = mk_tok(FID_PAYLOAD, {16'd0, data_byte}, ST_OK); ntok = ntok + 2'd1;
        if (pcnt_r != CNT_SAT)
          pcnt_nxt = pcnt_r + 24'd1;
      end
      default: begin
        // non-AVC data is dropped
      end
    endcase

    // End of tag: status from where the parse stopped, then restart
    if (tag_last) begin
      if (phase_nxt <= PH_FIRST)
        st = ST_TRUNC_HDR;
      else if (phase_nxt == PH_DROP)
        st = ST_NOT_AVC;
      else if (phase_nxt < PH_CHROMA)
        st = ST_TRUNC_REC;
      else
        st = ST_OK;
      toks[ntok] = mk_tok(FID_END, pcnt_nxt, st); ntok = ntok + 2'd1;
      phase_nxt = PH_TYPE;
      bif_nxt   = '0;
      acc_nxt   = '0;
      psr_nxt   = '0;
      pcnt_nxt  = '0;
      avc_nxt   = 1'b0;
    end
  end

  // Parse state, advanced once per accepted byte; codec id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      bif_r   <= '0;
      acc_r   <= '0;
      psr_r   <= '0;
      pcnt_r  <= '0;
      avc_r   <= 1'b0;
      codec_r <= AVC_CODEC_RST;
    end else begin
      if (cfg_wr_en)
        codec_r <= cfg_wr_data;
      if (byte_fire) begin
        phase_r <= phase_nxt;
        bif_r   <= bif_nxt;
        acc_r   <= acc_nxt;
        psr_r   <= psr_nxt;
        pcnt_r  <= pcnt_nxt;
        avc_r   <= avc_nxt;
      end
    end
  end

  assign stat.phase  = phase_r;
  assign stat.is_avc = avc_r;

endmodule

// ===== hdl/fatp_token_buf.sv =====
// Output register for up to three tokens of one byte, drained one per transaction.
// Depends on fatp_pkg.
module fatp_token_buf
  import fatp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,          // byte accepted
  input  token_t      toks [TOK_MAX],
  input  logic [1:0]  ntok,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output token_t      out_tok,
  output logic        out_last
);

  token_t     slot_r [TOK_MAX];
  logic [1:0] cnt_r;
  logic       fire;

  assign fire      = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_tok   = slot_r[0];
  assign out_last  = (cnt_r == 2'd1);
  // free now, or the last held token leaves this cycle
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  // Token slots: load a new burst or shift toward the head
  always_ff @(posedge clk) begin
    if (load && ntok != 2'd0) begin
      for (int i = 0; i < TOK_MAX; i++) slot_r[i] <= toks[i];
    end else if (fire) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load && ntok != 2'd0) begin
      cnt_r <= ntok;
    end else if (fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== hdl/flv_avc_tag_parser_top.sv =====
// FLV video tag / AVC configuration record parser, top level.
// Depends on fatp_pkg, fatp_parser, fatp_token_buf and assert_macros.svh.
//
// Takes one byte per transaction (header, then video data, tlast on the last
// byte of the tag) and returns (field id, value, status) tokens, tlast on the
// last token caused by a byte. The field id travels on out_tuser. Bytes that
// yield no token or one token stream at one byte per clock while the output
// is ready, so plain payload does too. A byte that yields several tokens
// stalls the input while the three-slot output register drains. The worst
// case is three tokens (frame type, codec id and end together). The first
// token appears in the cycle after its byte is accepted.
// The codec id that selects AVC parsing is written through cfg_wr_en /
// cfg_wr_data (reset 7); the user writes it while no tag is in flight, the block does not enforce this.
`include "assert_macros.svh"

module flv_avc_tag_parser_top
  import fatp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,    // avc_codec_id
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // [7:0] data_byte
  input  logic        in_tlast,       // tag_last
  // output tokens
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,      // [23:0] field_value, [25:24] end_status,
                                      // [31:26] zero
  output logic [4:0]  out_tuser,      // [4:0] field_id
  output logic        out_tlast       // last_of_run
);

  token_t      toks [TOK_MAX];
  logic [1:0]  ntok;
  parse_stat_t stat;
  logic        in_fire;
  token_t      head;
  logic        tok_is_end;
  logic        tag_done;
  logic        parse_idle;

  assign in_fire = in_tvalid && in_tready;

  fatp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_fire  (in_fire),
    .data_byte  (in_tdata),
    .tag_last   (in_tlast),
    .toks       (toks),
    .ntok       (ntok),
    .stat       (stat)
  );

  fatp_token_buf u_tbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .toks     (toks),
    .ntok     (ntok),
    .can_load (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_tok  (head),
    .out_last (out_tlast)
  );

  assign out_tdata = {6'd0, head.status, head.value};
  assign out_tuser = head.id;

  // Terms for the checks
  assign tok_is_end = (head.id == FID_END);
  assign tag_done   = in_fire && in_tlast;
  assign parse_idle = (stat.phase == PH_TYPE) && !stat.is_avc;

  // Checks
  `FATP_ASSERT(a_stall_has_tokens, !in_tready |-> out_tvalid, "input stalled, no token held")
  `FATP_ASSERT(a_end_is_last, (out_tvalid && tok_is_end) |-> out_tlast, "end token not last")
  `FATP_ASSERT(a_tag_end_restart, tag_done |=> parse_idle, "parser not restarted at tag end")
  `FATP_ASSERT(a_status_only_end, (out_tvalid && !tok_is_end) |-> (head.status == ST_OK), "status on a non-end token")

endmodule
